[rtl/core/rrfmc_pkg.sv]
// ----------------------------------------------------------------------------
// rrfmc_pkg
// Types and constants shared by the flight mode controller modules.
// ----------------------------------------------------------------------------
package rrfmc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [17:0] ArcOffsetCdeg = 18'sd9000;
  localparam logic signed [17:0] ArcTolCdeg    = 18'sd300;
  localparam logic signed [17:0] FullCdeg      = 18'sd36000;
  localparam logic signed [17:0] HalfCdeg      = 18'sd18000;
  localparam logic [7:0]         CountMax      = 8'hFF;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_IDLE     = 3'd0,
    ACT_STRAIGHT = 3'd1,
    ACT_TURN     = 3'd2,
    ACT_AVOID    = 3'd3,
    ACT_EMERG    = 3'd4,
    ACT_FINISHED = 3'd5,
    ACT_DISARM   = 3'd6
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INNER_BOUND = 3'd0,
    CFG_ABORT_BOUND = 3'd1,
    CFG_AVOID_ENTER = 3'd2,
    CFG_AVOID_EXIT  = 3'd3,
    CFG_AVOID_LAND  = 3'd4,
    CFG_DEMO_TICKS  = 3'd5,
    CFG_CONFIRM     = 3'd6,
    CFG_EXIT_COUNT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic               command;
    logic [15:0]        dist_front_mm;
    logic [15:0]        dist_side_mm;
    logic signed [15:0] yaw_cdeg;
    logic               yaw_valid;
    logic               kill;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] routines_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] turn_bound_mm;
    logic [15:0] abort_bound_mm;
    logic [15:0] avoid_enter_mm;
    logic [15:0] avoid_exit_mm;
    logic [15:0] avoid_land_mm;
    logic [15:0] demo_ticks;
    logic [7:0]  confirm_count;
    logic [7:0]  avoid_exit_count;
  } cfg_t;

  typedef struct packed {
    logic               running;
    logic               turning;
    logic               arc_tracking;
    logic               arc_cooldown;
    logic signed [15:0] target_heading;
    logic [7:0]         leave_count;
    logic [7:0]         return_count;
    logic [7:0]         far_count;
    logic               avoiding;
    logic [7:0]         near_count;
    logic [7:0]         clear_count;
    logic [15:0]        elapsed_ticks;
    logic [7:0]         routine_count;
  } state_t;

endpackage

[rtl/core/rrfmc_step.sv]
// ----------------------------------------------------------------------------
// rrfmc_step
// Next-state and action logic for one start command or control tick.
// ----------------------------------------------------------------------------
module rrfmc_step
  import rrfmc_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  state_t    st,
  output state_t    st_nxt,
  output out_item_t result
);

  logic               far_hit;
  logic [7:0]         far_inc;
  logic signed [17:0] yaw_ext;
  logic signed [17:0] tgt_raw;
  logic signed [17:0] diff;
  logic               arc_hit;

  always_comb begin
    far_inc = (st.far_count < CountMax) ? st.far_count + 8'd1 : st.far_count;
    far_hit = (item.dist_front_mm > cfg.abort_bound_mm);
    yaw_ext = {{2{item.yaw_cdeg[15]}}, item.yaw_cdeg};
    tgt_raw = yaw_ext - ArcOffsetCdeg;
    if (tgt_raw <= -HalfCdeg) begin
      tgt_raw = tgt_raw + FullCdeg;
    end
    if (tgt_raw > HalfCdeg) begin
      tgt_raw = tgt_raw - FullCdeg;
    end
  end

  always_comb begin
    st_nxt = st;
    diff = '0;
    arc_hit = 1'b0;
    result.action = ACT_IDLE;
    if (item.command == CMD_START) begin
      st_nxt.turning        = 1'b0;
      st_nxt.arc_tracking   = 1'b0;
      st_nxt.arc_cooldown   = 1'b0;
      st_nxt.target_heading = '0;
      st_nxt.leave_count    = '0;
      st_nxt.return_count   = '0;
      st_nxt.elapsed_ticks  = '0;
      st_nxt.routine_count  = '0;
      st_nxt.running        = !item.kill;
      result.action         = item.kill ? ACT_DISARM : ACT_STRAIGHT;
    end else if (!st.running) begin
      st_nxt.far_count = far_hit ? far_inc : 8'd0;
      result.action    = (far_hit && far_inc >= cfg.confirm_count) ? ACT_EMERG : ACT_IDLE;
    end else if (item.kill) begin
      st_nxt.running = 1'b0;
      result.action  = ACT_DISARM;
    end else if (st.elapsed_ticks >= cfg.demo_ticks) begin
      st_nxt.running = 1'b0;
      result.action  = ACT_FINISHED;
    end else begin
      st_nxt.elapsed_ticks = st.elapsed_ticks + 16'd1;
      st_nxt.far_count     = far_hit ? far_inc : 8'd0;
      if (far_hit && far_inc >= cfg.confirm_count) begin
        st_nxt.running = 1'b0;
        result.action  = ACT_EMERG;
      end else begin
        if (st.arc_cooldown && item.dist_front_mm != 16'd0 &&
            item.dist_front_mm <= cfg.turn_bound_mm) begin
          st_nxt.arc_cooldown = 1'b0;
        end

        if (!st.turning) begin
          if (item.dist_front_mm >= cfg.turn_bound_mm) begin
            if (!st_nxt.arc_cooldown) begin
              st_nxt.leave_count = st.leave_count + 8'd1;
              if (st_nxt.leave_count >= cfg.confirm_count) begin
                st_nxt.turning        = 1'b1;
                st_nxt.leave_count    = '0;
                st_nxt.target_heading = tgt_raw[15:0];
                st_nxt.arc_tracking   = item.yaw_valid;
              end
            end
          end else begin
            st_nxt.leave_count = '0;
          end
        end else begin
          if (item.dist_front_mm <= cfg.turn_bound_mm) begin
            st_nxt.return_count = st.return_count + 8'd1;
            if (st_nxt.return_count >= cfg.confirm_count) begin
              st_nxt.turning       = 1'b0;
              st_nxt.return_count  = '0;
              st_nxt.routine_count = st.routine_count + 8'd1;
            end
          end else begin
            st_nxt.return_count = '0;
          end
        end

        if (st_nxt.turning && st_nxt.arc_tracking) begin
          if (item.yaw_valid) begin
            diff = yaw_ext - {{2{st_nxt.target_heading[15]}}, st_nxt.target_heading};
            arc_hit = (diff >= -ArcTolCdeg && diff <= ArcTolCdeg) ||
                      (diff >= FullCdeg - ArcTolCdeg && diff <= FullCdeg + ArcTolCdeg);
            if (arc_hit) begin
              st_nxt.turning      = 1'b0;
              st_nxt.arc_tracking = 1'b0;
              st_nxt.arc_cooldown = 1'b1;
              st_nxt.return_count = '0;
            end
          end else begin
            st_nxt.arc_tracking = 1'b0;
          end
        end

        if (st.avoiding && item.dist_side_mm != 16'd0 &&
            item.dist_side_mm <= cfg.avoid_land_mm) begin
          st_nxt.running = 1'b0;
          result.action  = ACT_EMERG;
        end else begin
          if (!st.avoiding) begin
            if (item.dist_side_mm != 16'd0 && item.dist_side_mm <= cfg.avoid_enter_mm) begin
              st_nxt.near_count = st.near_count + 8'd1;
              if (st_nxt.near_count >= cfg.confirm_count) begin
                st_nxt.avoiding    = 1'b1;
                st_nxt.near_count  = '0;
                st_nxt.clear_count = '0;
              end
            end else begin
              st_nxt.near_count = '0;
            end
          end else begin
            if (item.dist_side_mm >= cfg.avoid_exit_mm) begin
              st_nxt.clear_count = st.clear_count + 8'd1;
              if (st_nxt.clear_count >= cfg.avoid_exit_count) begin
                st_nxt.avoiding    = 1'b0;
                st_nxt.clear_count = '0;
                st_nxt.near_count  = '0;
              end
            end else begin
              st_nxt.clear_count = '0;
            end
          end
          priority if (st_nxt.avoiding) begin
            result.action = ACT_AVOID;
          end else if (st_nxt.turning) begin
            result.action = ACT_TURN;
          end else begin
            result.action = ACT_STRAIGHT;
          end
        end
      end
    end
    result.routines_done = st_nxt.routine_count;
  end

endmodule

[rtl/core/range_reactive_flight_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// range_reactive_flight_mode_controller_unit
// Flight mode controller driven by start commands and range/yaw control ticks.
// ----------------------------------------------------------------------------
// Each accepted word is a start command or one control tick and yields exactly
// one result word carrying the action code and the completed routine count.
// A word is registered on input, evaluated combinationally against the mode
// state and written to the output register, so a new word is taken every cycle
// while the output is not stalled; the result passes through the input register
// and then the output register. The output register and the input register
// together let the block accept one more word while a finished result waits.
// Configuration writes are always ready and should be issued only while the
// block is idle.
module range_reactive_flight_mode_controller_unit
  import rrfmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  out_item_t step_result;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      adv;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  rrfmc_step u_step (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_bound_mm    <= 16'd1750;
      cfg_r.abort_bound_mm   <= 16'd3600;
      cfg_r.avoid_enter_mm   <= 16'd2000;
      cfg_r.avoid_exit_mm    <= 16'd2100;
      cfg_r.avoid_land_mm    <= 16'd500;
      cfg_r.demo_ticks       <= 16'd1500;
      cfg_r.confirm_count    <= 8'd2;
      cfg_r.avoid_exit_count <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INNER_BOUND: cfg_r.turn_bound_mm    <= cfg_data;
        CFG_ABORT_BOUND: cfg_r.abort_bound_mm   <= cfg_data;
        CFG_AVOID_ENTER: cfg_r.avoid_enter_mm   <= cfg_data;
        CFG_AVOID_EXIT:  cfg_r.avoid_exit_mm    <= cfg_data;
        CFG_AVOID_LAND:  cfg_r.avoid_land_mm    <= cfg_data;
        CFG_DEMO_TICKS:  cfg_r.demo_ticks       <= cfg_data;
        CFG_CONFIRM:     cfg_r.confirm_count    <= cfg_data[7:0];
        CFG_EXIT_COUNT:  cfg_r.avoid_exit_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= step_result;
    end
  end

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_item_r.command == CMD_START) |=> (st_r.running == !$past(s1_item_r.kill)))
    else $error("start command did not set running from kill");

  a_turn_vs_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.turning && st_r.arc_cooldown))
    else $error("turning while arc cooldown is active");

  a_avoid_near_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.avoiding |-> (st_r.near_count == 8'd0))
    else $error("near count nonzero while avoiding");

  a_idle_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.avoiding |-> (st_r.clear_count == 8'd0))
    else $error("clear count nonzero while not avoiding");

  a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_valid_r && out_item_r.routines_done == st_r.routine_count))
    else $error("result word does not match updated routine count");

endmodule

[verif/range_reactive_flight_mode_controller_unit_tb.sv]
// ----------------------------------------------------------------------------
// range_reactive_flight_mode_controller_unit_tb
// Self-checking testbench for the range-reactive flight mode controller.
// A short directed table walks reset values, kill, far abort, turn entry and
// arc completion (including the heading wrap), return on the inner bound and
// avoidance with its landing abort. Random flights follow under several limit
// settings, extremes included. Each result word is compared with a behavioral
// model of the controller kept in the testbench, or with the result pinned
// in its directed row, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module range_reactive_flight_mode_controller_unit_tb
  import rrfmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  word;
    bit        pinned;
    out_item_t result;
  } drill_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  bit        pinned_valid = 1'b0;
  out_item_t pinned_result = '0;
  bit        tx_gaps_on = 1'b1;
  bit        rx_gaps_on = 1'b1;
  int        hold_cycles = 0;
  int        mismatches = 0;

  out_item_t  expected_results[$];
  drill_row_t drill_rows[$];

  cfg_t        limits;
  logic        run_st, turning_st, tracking_st, cooldown_st, avoiding_st;
  int          target_cdeg;
  logic [7:0]  leave_cnt, return_cnt, far_cnt, near_cnt, clear_cnt, routines;
  logic [15:0] elapsed;

  range_reactive_flight_mode_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] sat16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic int wrap_cdeg(int a);
    if (a <= -int'(HalfCdeg)) a += int'(FullCdeg);
    if (a > int'(HalfCdeg)) a -= int'(FullCdeg);
    return a;
  endfunction

  function automatic int mag_cdeg(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit far_confirmed(logic [15:0] d0);
    if (d0 > limits.abort_bound_mm) begin
      if (far_cnt != CountMax) far_cnt++;
      return far_cnt >= limits.confirm_count;
    end
    far_cnt = '0;
    return 1'b0;
  endfunction

  function automatic out_item_t flight_mode_step(in_item_t w);
    out_item_t   res;
    action_t     act;
    int          yaw, diff;
    logic [15:0] d0, d1;
    yaw = int'($signed(w.yaw_cdeg));
    d0 = w.dist_front_mm;
    d1 = w.dist_side_mm;
    if (w.command == CMD_START) begin
      turning_st = 1'b0;
      tracking_st = 1'b0;
      cooldown_st = 1'b0;
      target_cdeg = 0;
      leave_cnt = '0;
      return_cnt = '0;
      elapsed = '0;
      routines = '0;
      run_st = !w.kill;
      act = w.kill ? ACT_DISARM : ACT_STRAIGHT;
    end else if (!run_st) begin
      act = far_confirmed(d0) ? ACT_EMERG : ACT_IDLE;
    end else if (w.kill) begin
      run_st = 1'b0;
      act = ACT_DISARM;
    end else if (elapsed >= limits.demo_ticks) begin
      run_st = 1'b0;
      act = ACT_FINISHED;
    end else begin
      elapsed++;
      if (far_confirmed(d0)) begin
        run_st = 1'b0;
        act = ACT_EMERG;
      end else begin
        if (cooldown_st && d0 != 0 && d0 <= limits.turn_bound_mm) cooldown_st = 1'b0;
        if (!turning_st) begin
          if (d0 >= limits.turn_bound_mm) begin
            if (!cooldown_st) begin
              leave_cnt++;
              if (leave_cnt >= limits.confirm_count) begin
                turning_st = 1'b1;
                leave_cnt = '0;
                target_cdeg = wrap_cdeg(yaw - int'(ArcOffsetCdeg));
                tracking_st = w.yaw_valid;
              end
            end
          end else begin
            leave_cnt = '0;
          end
        end else begin
          if (d0 <= limits.turn_bound_mm) begin
            return_cnt++;
            if (return_cnt >= limits.confirm_count) begin
              turning_st = 1'b0;
              return_cnt = '0;
              routines++;
            end
          end else begin
            return_cnt = '0;
          end
        end
        if (turning_st && tracking_st) begin
          if (w.yaw_valid) begin
            diff = yaw - target_cdeg;
            if (mag_cdeg(diff) <= int'(ArcTolCdeg) ||
                mag_cdeg(diff - int'(FullCdeg)) <= int'(ArcTolCdeg)) begin
              turning_st = 1'b0;
              tracking_st = 1'b0;
              cooldown_st = 1'b1;
              return_cnt = '0;
            end
          end else begin
            tracking_st = 1'b0;
          end
        end
        if (avoiding_st && d1 != 0 && d1 <= limits.avoid_land_mm) begin
          run_st = 1'b0;
          act = ACT_EMERG;
        end else begin
          if (!avoiding_st) begin
            if (d1 != 0 && d1 <= limits.avoid_enter_mm) begin
              near_cnt++;
              if (near_cnt >= limits.confirm_count) begin
                avoiding_st = 1'b1;
                near_cnt = '0;
                clear_cnt = '0;
              end
            end else begin
              near_cnt = '0;
            end
          end else begin
            if (d1 >= limits.avoid_exit_mm) begin
              clear_cnt++;
              if (clear_cnt >= limits.avoid_exit_count) begin
                avoiding_st = 1'b0;
                clear_cnt = '0;
                near_cnt = '0;
              end
            end else begin
              clear_cnt = '0;
            end
          end
          act = avoiding_st ? ACT_AVOID : (turning_st ? ACT_TURN : ACT_STRAIGHT);
        end
      end
    end
    res.action = act;
    res.routines_done = routines;
    return res;
  endfunction

  // Random flight words lean on the current limits and the model state, so
  // that turns, arc completions and avoidance are reached often.
  function automatic in_item_t next_flight_word();
    in_item_t w;
    int       pick, d0, d1, yaw;
    int       inner, far_mm, enter, clear, land;
    inner = limits.turn_bound_mm;
    far_mm = limits.abort_bound_mm;
    enter = limits.avoid_enter_mm;
    clear = limits.avoid_exit_mm;
    land = limits.avoid_land_mm;
    w.command = CMD_TICK;
    w.kill = 1'b0;
    w.yaw_valid = ($urandom_range(0, 99) < 92);
    pick = $urandom_range(0, 99);
    if (!run_st) begin
      if (pick < 65) w.command = CMD_START;
      w.kill = ($urandom_range(0, 99) < 8);
    end else if (pick < 2) begin
      w.command = CMD_START;
    end else if (pick < 4) begin
      w.kill = 1'b1;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) d0 = 0;
    else if (pick < 10) d0 = 65535;
    else if (pick < 15) d0 = far_mm + int'($urandom_range(1, 300));
    else if (pick < 50) d0 = inner - int'($urandom_range(0, 600));
    else if (pick < 88) d0 = inner + int'($urandom_range(0, 600));
    else d0 = int'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < (avoiding_st ? 80 : 65)) d1 = clear + int'($urandom_range(0, 3000));
    else if (pick < 85) d1 = enter - int'($urandom_range(0, 400));
    else if (pick < 89) d1 = 0;
    else if (pick < 92) d1 = land - int'($urandom_range(0, 100));
    else d1 = int'($urandom_range(0, 65535));
    if (turning_st && tracking_st && $urandom_range(0, 99) < 45) begin
      yaw = target_cdeg + int'($urandom_range(0, 800)) - 400;
      if (yaw > 18000) yaw -= 36000;
      if (yaw < -18000) yaw += 36000;
    end else if ($urandom_range(0, 99) < 5) begin
      yaw = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      yaw = int'($urandom_range(0, 36000)) - 18000;
    end
    w.dist_front_mm = sat16(d0);
    w.dist_side_mm = sat16(d1);
    w.yaw_cdeg = yaw[15:0];
    return w;
  endfunction

  function automatic void drill(cmd_t c, int d0, int d1, int yaw, bit yv, bit k,
                                bit pin = 1'b0, action_t a = ACT_IDLE, int rd = 0);
    drill_row_t r;
    r.word.command = c;
    r.word.dist_front_mm = d0[15:0];
    r.word.dist_side_mm = d1[15:0];
    r.word.yaw_cdeg = yaw[15:0];
    r.word.yaw_valid = yv;
    r.word.kill = k;
    r.pinned = pin;
    r.result.action = a;
    r.result.routines_done = rd[7:0];
    drill_rows.push_back(r);
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want, predicted;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result word with nothing outstanding, action", out_data.action, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.action !== want.action)
            note_mismatch("action", out_data.action, want.action);
          if (out_data.routines_done !== want.routines_done)
            note_mismatch("routines_done", out_data.routines_done, want.routines_done);
        end
      end
      if (in_valid && !in_stall) begin
        predicted = flight_mode_step(in_data);
        expected_results.push_back(pinned_valid ? pinned_result : predicted);
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        stall_left = int'($urandom_range(1, 6)) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_word(bit directed, drill_row_t row);
    @(negedge clk);
    if (!directed) begin
      row.word = next_flight_word();
      row.pinned = 1'b0;
      row.result = '0;
    end
    in_valid <= 1'b1;
    in_data <= row.word;
    pinned_valid <= row.pinned;
    pinned_result <= row.result;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INNER_BOUND: limits.turn_bound_mm = value;
      CFG_ABORT_BOUND: limits.abort_bound_mm = value;
      CFG_AVOID_ENTER: limits.avoid_enter_mm = value;
      CFG_AVOID_EXIT:  limits.avoid_exit_mm = value;
      CFG_AVOID_LAND:  limits.avoid_land_mm = value;
      CFG_DEMO_TICKS:  limits.demo_ticks = value;
      CFG_CONFIRM:     limits.confirm_count = value[7:0];
      CFG_EXIT_COUNT:  limits.avoid_exit_count = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_limits(int inner, int far_mm, int enter, int clear, int land,
                                int demo, int confirm, int exit_cnt);
    wait_all_results();
    repeat (4) @(negedge clk);
    write_reg(CFG_INNER_BOUND, sat16(inner));
    write_reg(CFG_ABORT_BOUND, sat16(far_mm));
    write_reg(CFG_AVOID_ENTER, sat16(enter));
    write_reg(CFG_AVOID_EXIT, sat16(clear));
    write_reg(CFG_AVOID_LAND, sat16(land));
    write_reg(CFG_DEMO_TICKS, sat16(demo));
    write_reg(CFG_CONFIRM, sat16(confirm));
    write_reg(CFG_EXIT_COUNT, sat16(exit_cnt));
  endtask

  initial begin
    drill_row_t spare;
    int         inner, n_words;
    limits = '{16'd1750, 16'd3600, 16'd2000, 16'd2100, 16'd500, 16'd1500, 8'd2, 8'd10};
    {run_st, turning_st, tracking_st, cooldown_st, avoiding_st} = '0;
    target_cdeg = 0;
    {leave_cnt, return_cnt, far_cnt, near_cnt, clear_cnt, routines} = '0;
    elapsed = '0;
    spare = '{default: '0};

    drill(CMD_TICK, 0, 0, 0, 1, 0, 1, ACT_IDLE, 0);
    drill(CMD_TICK, 65535, 65535, 18000, 0, 1, 1, ACT_IDLE, 0);
    drill(CMD_TICK, 65535, 65535, 18000, 0, 0, 1, ACT_EMERG, 0);
    drill(CMD_START, 0, 0, 0, 1, 1, 1, ACT_DISARM, 0);
    drill(CMD_START, 0, 0, 0, 1, 0, 1, ACT_STRAIGHT, 0);
    drill(CMD_TICK, 1000, 3000, 0, 1, 0);
    drill(CMD_TICK, 3000, 3000, 0, 1, 0);
    drill(CMD_TICK, 3000, 3000, 0, 1, 0);
    drill(CMD_TICK, 3000, 3000, -8800, 1, 0);
    drill(CMD_TICK, 3000, 3000, -8800, 1, 0);
    drill(CMD_TICK, 1000, 3000, 0, 1, 0);
    drill(CMD_TICK, 3000, 3000, -8900, 1, 0);
    drill(CMD_TICK, 3000, 3000, -8900, 1, 0);
    drill(CMD_TICK, 3000, 3000, 18000, 1, 0);
    drill(CMD_TICK, 500, 3000, 0, 1, 0);
    drill(CMD_TICK, 1750, 3000, 0, 0, 0);
    drill(CMD_TICK, 1750, 3000, 0, 0, 0);
    drill(CMD_TICK, 1750, 3000, 0, 0, 0);
    drill(CMD_TICK, 0, 3000, 0, 1, 0);
    drill(CMD_TICK, 1000, 2000, 0, 1, 0);
    drill(CMD_TICK, 1000, 2000, 0, 1, 0);
    drill(CMD_TICK, 1000, 500, 0, 1, 0, 1, ACT_EMERG, 1);
    drill(CMD_START, 1000, 3000, 0, 1, 0, 1, ACT_STRAIGHT, 0);
    drill(CMD_TICK, 1000, 65535, -18000, 1, 0);
    drill(CMD_TICK, 1000, 3000, 0, 1, 1, 1, ACT_DISARM, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (drill_rows[i]) begin
      if (tx_gaps_on && $urandom_range(0, 99) < 20) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (int'($urandom_range(1, 6)) - 1) @(negedge clk);
      end
      offer_word(1'b1, drill_rows[i]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_limits(1750, 3600, 2000, 2100, 500, 300, 2, 3);
        1: program_limits(0, 0, 0, 0, 0, 1, 1, 1);
        2: program_limits(65535, 65535, 65535, 65535, 65535, 65535, 255, 255);
        default: begin
          inner = int'($urandom_range(300, 4000));
          n_words = int'($urandom_range(300, 3000));
          program_limits(inner, inner + int'($urandom_range(0, 3000)), n_words,
                         n_words + int'($urandom_range(0, 600)),
                         int'($urandom_range(0, n_words / 2)),
                         int'($urandom_range(10, 150)), int'($urandom_range(1, 4)),
                         int'($urandom_range(1, 6)));
        end
      endcase
      tx_gaps_on = (ph != 5);
      rx_gaps_on = (ph != 5);
      n_words = (ph == 1 || ph == 2) ? 120 : 200;
      for (int i = 0; i < n_words; i++) begin
        if (ph == 0 && i == 30) hold_cycles = 60;
        if (ph == 3 && i == 100) wait_all_results();
        if (tx_gaps_on && $urandom_range(0, 99) < 12) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (int'($urandom_range(1, 6)) - 1) @(negedge clk);
        end
        offer_word(1'b0, spare);
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[range_reactive_flight_mode_controller_unit.f]
rtl/core/rrfmc_pkg.sv
rtl/core/rrfmc_step.sv
rtl/core/range_reactive_flight_mode_controller_unit.sv
verif/range_reactive_flight_mode_controller_unit_tb.sv
